[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bsc_pkg.sv]
package bsc_pkg;

  // Pipeline depth: stage 0 takes the sample, the last stage is the output register.
  localparam int NumStages = 16;

  localparam int SampleW  = 24;
  localparam int ResultW  = 32;
  localparam int CfgDataW = 48;

  // Signed 16-bit offset subtracted from the first two pressure coefficients.
  localparam int PressOffset = 16384;

  typedef enum logic [1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_MID  = 2'd2,
    CFG_PRESS_HIGH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleW-1:0] temp_sample;
    logic [SampleW-1:0] press_sample;
  } sample_t;

  typedef struct packed {
    logic signed [ResultW-1:0] temp_millideg;
    logic signed [ResultW-1:0] press_millipascal;
  } result_t;

  typedef struct packed {
    cfg_reg_e            index;
    logic [CfgDataW-1:0] data;
  } cfg_req_t;

endpackage

[sv/bsc_ifs.sv]
interface bsc_sample_if ();
  import bsc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bsc_result_if ();
  import bsc_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bsc_cfg_if ();
  import bsc_pkg::*;

  logic     valid;
  logic     ready;
  cfg_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/baro_sensor_compensation.sv]
// Channel    Dir  Payload                                     Request taken when
// sample_i   in   temp_sample[23:0], press_sample[23:0]       valid && ready
// result_o   out  temp_millideg[31:0], press_millipascal      valid && ready
// cfg_i      in   index (cfg_reg_e), data[47:0]               valid && ready (always ready)
//
// Throughput: one sample request per cycle while stage 0 is not stalled; the output
// register is the last of the 16 pipeline stages. Every wide product is split into two
// narrow partial products in one stage and summed in the next.
// Reset (rst_ni low, async) clears all valid bits and the calibration registers.
// Stalls: each stage holds while the one after it is full and stalled, so bubbles
// close up and a new request is taken whenever stage 0 can move.

`include "assert_macros.svh"

module baro_sensor_compensation (
  input  logic clk_i,
  input  logic rst_ni,
  bsc_sample_if.sink   sample_i,
  bsc_result_if.source result_o,
  bsc_cfg_if.sink      cfg_i
);
  import bsc_pkg::*;

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [39:0] cal_temp_q;
  logic [47:0] cal_plo_q;
  logic [47:0] cal_pmid_q;
  logic [31:0] cal_phi_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q <= '0;
      cal_plo_q  <= '0;
      cal_pmid_q <= '0;
      cal_phi_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_TEMP:       cal_temp_q <= cfg_i.payload.data[39:0];
        CFG_PRESS_LOW:  cal_plo_q  <= cfg_i.payload.data;
        CFG_PRESS_MID:  cal_pmid_q <= cfg_i.payload.data;
        CFG_PRESS_HIGH: cal_phi_q  <= cfg_i.payload.data[31:0];
        default: ;
      endcase
    end
  end

  // Coefficient unpack (little-endian bytes). The user must change calibration only while
  // idle; the block itself does not enforce this, and every stage reads these directly.
  logic [15:0]        t1_c, t2_c, p5_c, p6_c;
  logic signed [7:0]  t3_c, p3_c, p4_c, p7_c, p8_c, p10_c, p11_c;
  logic signed [16:0] p1_c, p2_c;
  logic signed [15:0] p9_c;

  assign t1_c  = cal_temp_q[15:0];
  assign t2_c  = cal_temp_q[31:16];
  assign t3_c  = $signed(cal_temp_q[39:32]);
  assign p1_c  = $signed({cal_plo_q[15], cal_plo_q[15:0]}) - 17'(PressOffset);
  assign p2_c  = $signed({cal_plo_q[31], cal_plo_q[31:16]}) - 17'(PressOffset);
  assign p3_c  = $signed(cal_plo_q[39:32]);
  assign p4_c  = $signed(cal_plo_q[47:40]);
  assign p5_c  = cal_pmid_q[15:0];
  assign p6_c  = cal_pmid_q[31:16];
  assign p7_c  = $signed(cal_pmid_q[39:32]);
  assign p8_c  = $signed(cal_pmid_q[47:40]);
  assign p9_c  = $signed(cal_phi_q[15:0]);
  assign p10_c = $signed(cal_phi_q[23:16]);
  assign p11_c = $signed(cal_phi_q[31:24]);

  // ---------------------------------------------------------------------------
  // Pipeline control: per-stage enable, bubbles collapse
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] stage_en;

  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || result_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign sample_i.ready = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= sample_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  // temperature chain
  logic signed [25:0] s0_s_q, s1_s_q, s2_s_q;
  logic [23:0]        s0_p_q, s1_p_q, s2_p_q, s3_p_q, s4_p_q, s5_p_q, s6_p_q, s7_p_q;
  logic [23:0]        s8_p_q, s9_p_q, s10_p_q, s11_p_q;
  logic signed [33:0] s1_sa_q;
  logic signed [36:0] s2_b_q;
  logic signed [44:0] s3_pl_q, s3_ph_q;
  logic signed [29:0] s4_t_q, s5_t_q, s6_t_q, s7_t_q, s8_t_q;
  logic [31:0]        s5_tm_q, s6_tm_q, s7_tm_q, s8_tm_q, s9_tm_q, s10_tm_q, s11_tm_q;
  logic [31:0]        s12_tm_q, s13_tm_q, s14_tm_q;
  // pressure chain
  logic signed [37:0] s5_tp8_q, s5_tp4_q, s5_tp10_q;
  logic signed [32:0] s5_pp11_q;
  logic signed [38:0] s6_c1_q, s6_c2_q;
  logic signed [40:0] s6_d_q;
  logic signed [50:0] s7_l1_q, s7_l2_q;
  logic signed [48:0] s7_h1_q, s7_h2_q;
  logic signed [46:0] s7_lv_q;
  logic signed [44:0] s7_hv_q;
  logic signed [37:0] s8_a1_q;
  logic signed [39:0] s8_a2_q, s8_a3_q, s9_a3_q, s10_a3_q;
  logic signed [49:0] s9_l1_q, s9_h2_q;
  logic signed [48:0] s9_h1_q, s12_l_q;
  logic signed [50:0] s9_l2_q;
  logic signed [63:0] s10_q1_q, s11_q1_q, s12_q1_q, s13_q1_q;
  logic signed [43:0] s10_q2_q;
  logic signed [44:0] s11_e_q;
  logic signed [46:0] s12_h_q;
  logic signed [59:0] s13_g_q;
  logic signed [47:0] s14_w_q;
  result_t            res_q;

  // ---------------------------------------------------------------------------
  // Combinational stage logic
  // ---------------------------------------------------------------------------
  logic signed [25:0] s0_s_d;
  logic signed [33:0] s1_sa_d;
  logic signed [36:0] s2_b_d;
  logic signed [44:0] s3_pl_d, s3_ph_d;
  logic signed [62:0] s4_tf, s4_ph_x, s4_pl_x;
  logic signed [47:0] s5_t_x, s5_tm;
  logic signed [37:0] s5_tp8_d, s5_tp4_d, s5_tp10_d;
  logic signed [32:0] s5_pp11_d;
  logic signed [38:0] s6_p7_x, s6_p3_x, s6_tp8_x, s6_tp4_x;
  logic signed [40:0] s6_p9_x, s6_tp10_x, s6_pp11_x, s6_d_d;
  logic signed [50:0] s7_l1_d, s7_l2_d;
  logic signed [48:0] s7_h1_d, s7_h2_d;
  logic signed [46:0] s7_lv_d;
  logic signed [44:0] s7_hv_d;
  logic signed [24:0] p_s7, p_s12;
  logic signed [63:0] s8_r1, s8_r2, s8_v1, s8_p2_x;
  logic signed [49:0] s9_l1_d, s9_h2_d;
  logic signed [48:0] s9_h1_d;
  logic signed [50:0] s9_l2_d;
  logic signed [63:0] s10_q1, s10_q2, s10_p1_x;
  logic signed [44:0] s11_e_d;
  logic signed [48:0] s12_l_d;
  logic signed [46:0] s12_h_d;
  logic signed [63:0] s13_g;
  logic signed [63:0] s14_w, s14_g_x;
  logic signed [57:0] s15_x, s15_y;

  // s: raw temperature minus T1 << 8
  assign s0_s_d = $signed({2'b00, sample_i.payload.temp_sample})
                - $signed({2'b00, t1_c, 8'h00});
  // s * T3
  assign s1_sa_d = s0_s_q * t3_c;
  // + T2 << 18
  assign s2_b_d = s1_sa_q + $signed({3'b000, t2_c, 18'h00000});
  // (…) * s, split at bit 18
  assign s3_pl_d = $signed({1'b0, s2_b_q[17:0]}) * s2_s_q;
  assign s3_ph_d = $signed(s2_b_q[36:18]) * s2_s_q;
  // recombine, keep >> 32
  assign s4_ph_x = s3_ph_q;
  assign s4_pl_x = s3_pl_q;
  assign s4_tf   = (s4_ph_x <<< 18) + s4_pl_x;

  // temperature result: (t * 1000) >> 16, multiply by 1024 - 16 - 8
  assign s5_t_x    = s4_t_q;
  assign s5_tm     = (s5_t_x <<< 10) - (s5_t_x <<< 4) - (s5_t_x <<< 3);
  assign s5_tp8_d  = s4_t_q * p8_c;
  assign s5_tp4_d  = s4_t_q * p4_c;
  assign s5_tp10_d = s4_t_q * p10_c;
  assign s5_pp11_d = $signed({1'b0, s4_p_q}) * p11_c;

  // first-order polynomial terms
  assign s6_p7_x   = $signed({p7_c, 23'h000000});
  assign s6_p3_x   = $signed({p3_c, 21'h000000});
  assign s6_tp8_x  = s5_tp8_q;
  assign s6_tp4_x  = s5_tp4_q;
  assign s6_p9_x   = $signed({p9_c, 17'h00000});
  assign s6_tp10_x = s5_tp10_q;
  assign s6_pp11_x = s5_pp11_q;
  // (q3 << 1) + p * P11
  assign s6_d_d    = s6_p9_x + (s6_tp10_x <<< 1) + s6_pp11_x;

  // t * c1, t * c2, p * d as split partial products
  assign p_s7    = $signed({1'b0, s6_p_q});
  assign s7_l1_d = s6_t_q * $signed({1'b0, s6_c1_q[19:0]});
  assign s7_h1_d = s6_t_q * $signed(s6_c1_q[38:20]);
  assign s7_l2_d = s6_t_q * $signed({1'b0, s6_c2_q[19:0]});
  assign s7_h2_d = s6_t_q * $signed(s6_c2_q[38:20]);
  assign s7_lv_d = p_s7 * $signed({1'b0, s6_d_q[20:0]});
  assign s7_hv_d = p_s7 * $signed(s6_d_q[40:21]);

  // r1, r2, v1 wrap at 64 bits
  assign s8_p2_x = p2_c;
  assign s8_r1 = $signed({7'h00, p6_c, 41'h0})
               + (64'(s7_h1_q) <<< 20) + 64'(s7_l1_q);
  assign s8_r2 = (s8_p2_x <<< 40) + (64'(s7_h2_q) <<< 20) + 64'(s7_l2_q);
  assign s8_v1 = (64'(s7_hv_q) <<< 21) + 64'(s7_lv_q);

  // t * (r1 >> 26), t * (r2 >> 24), split
  assign s9_l1_d = s8_t_q * $signed({1'b0, s8_a1_q[18:0]});
  assign s9_h1_d = s8_t_q * $signed(s8_a1_q[37:19]);
  assign s9_l2_d = s8_t_q * $signed({1'b0, s8_a2_q[19:0]});
  assign s9_h2_d = s8_t_q * $signed(s8_a2_q[39:20]);

  // q1, q2 wrap at 64 bits
  assign s10_p1_x = p1_c;
  assign s10_q1 = $signed({8'h00, p5_c, 40'h0})
                + (64'(s9_h1_q) <<< 19) + 64'(s9_l1_q);
  assign s10_q2 = (s10_p1_x <<< 41) + (64'(s9_h2_q) <<< 20) + 64'(s9_l2_q);

  // (q2 >> 20) + (v1 >> 24)
  assign s11_e_d = 45'(s10_q2_q) + 45'(s10_a3_q);

  // p * e, split at bit 23
  assign p_s12   = $signed({1'b0, s11_p_q});
  assign s12_l_d = p_s12 * $signed({1'b0, s11_e_q[22:0]});
  assign s12_h_d = p_s12 * $signed(s11_e_q[44:23]);

  assign s13_g   = (64'(s12_h_q) <<< 23) + 64'(s12_l_q);

  // w = q1 + (g >> 4)
  assign s14_g_x = s13_g_q;
  assign s14_w   = s13_q1_q + s14_g_x;

  // pressure result: ((w >> 16) * 1000) >> 21
  assign s15_x = s14_w_q;
  assign s15_y = (s15_x <<< 10) - (s15_x <<< 4) - (s15_x <<< 3);

  // ---------------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s0_s_q <= s0_s_d;
      s0_p_q <= sample_i.payload.press_sample;
    end
    if (stage_en[1]) begin
      s1_sa_q <= s1_sa_d;
      s1_s_q  <= s0_s_q;
      s1_p_q  <= s0_p_q;
    end
    if (stage_en[2]) begin
      s2_b_q <= s2_b_d;
      s2_s_q <= s1_s_q;
      s2_p_q <= s1_p_q;
    end
    if (stage_en[3]) begin
      s3_pl_q <= s3_pl_d;
      s3_ph_q <= s3_ph_d;
      s3_p_q  <= s2_p_q;
    end
    if (stage_en[4]) begin
      s4_t_q <= s4_tf[61:32];
      s4_p_q <= s3_p_q;
    end
    if (stage_en[5]) begin
      s5_tm_q   <= s5_tm[47:16];
      s5_t_q    <= s4_t_q;
      s5_p_q    <= s4_p_q;
      s5_tp8_q  <= s5_tp8_d;
      s5_tp4_q  <= s5_tp4_d;
      s5_tp10_q <= s5_tp10_d;
      s5_pp11_q <= s5_pp11_d;
    end
    if (stage_en[6]) begin
      s6_c1_q <= s6_p7_x + s6_tp8_x;
      s6_c2_q <= s6_p3_x + s6_tp4_x;
      s6_d_q  <= s6_d_d;
      s6_t_q  <= s5_t_q;
      s6_p_q  <= s5_p_q;
      s6_tm_q <= s5_tm_q;
    end
    if (stage_en[7]) begin
      s7_l1_q <= s7_l1_d;
      s7_h1_q <= s7_h1_d;
      s7_l2_q <= s7_l2_d;
      s7_h2_q <= s7_h2_d;
      s7_lv_q <= s7_lv_d;
      s7_hv_q <= s7_hv_d;
      s7_t_q  <= s6_t_q;
      s7_p_q  <= s6_p_q;
      s7_tm_q <= s6_tm_q;
    end
    if (stage_en[8]) begin
      s8_a1_q <= s8_r1[63:26];
      s8_a2_q <= s8_r2[63:24];
      s8_a3_q <= s8_v1[63:24];
      s8_t_q  <= s7_t_q;
      s8_p_q  <= s7_p_q;
      s8_tm_q <= s7_tm_q;
    end
    if (stage_en[9]) begin
      s9_l1_q <= s9_l1_d;
      s9_h1_q <= s9_h1_d;
      s9_l2_q <= s9_l2_d;
      s9_h2_q <= s9_h2_d;
      s9_a3_q <= s8_a3_q;
      s9_p_q  <= s8_p_q;
      s9_tm_q <= s8_tm_q;
    end
    if (stage_en[10]) begin
      s10_q1_q <= s10_q1;
      s10_q2_q <= s10_q2[63:20];
      s10_a3_q <= s9_a3_q;
      s10_p_q  <= s9_p_q;
      s10_tm_q <= s9_tm_q;
    end
    if (stage_en[11]) begin
      s11_e_q  <= s11_e_d;
      s11_q1_q <= s10_q1_q;
      s11_p_q  <= s10_p_q;
      s11_tm_q <= s10_tm_q;
    end
    if (stage_en[12]) begin
      s12_l_q  <= s12_l_d;
      s12_h_q  <= s12_h_d;
      s12_q1_q <= s11_q1_q;
      s12_tm_q <= s11_tm_q;
    end
    if (stage_en[13]) begin
      s13_g_q  <= s13_g[63:4];
      s13_q1_q <= s12_q1_q;
      s13_tm_q <= s12_tm_q;
    end
    if (stage_en[14]) begin
      s14_w_q  <= s14_w[63:16];
      s14_tm_q <= s13_tm_q;
    end
    if (stage_en[15]) begin
      res_q.temp_millideg     <= s14_tm_q;
      res_q.press_millipascal <= s15_y[52:21];
    end
  end

  assign result_o.valid   = valid_q[NumStages-1];
  assign result_o.payload = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Without an input request no item may appear in the pipeline.
  `BSC_ASSERT_NEXT(a_no_spawn, clk_i, rst_ni, !(sample_i.valid && sample_i.ready),
    $countones(valid_q) <= $past($countones(valid_q)), "pipeline item count grew")
  // Without an output request no item may leave the pipeline.
  `BSC_ASSERT_NEXT(a_no_drop, clk_i, rst_ni, !(result_o.valid && result_o.ready),
    $countones(valid_q) >= $past($countones(valid_q)), "pipeline item count shrank")
  // A full pipeline with a stalled output takes no new request.
  `BSC_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, (&valid_q) && !result_o.ready,
    !sample_i.ready, "request taken while pipeline is full and stalled")

endmodule
